// ----- hw/rtl/srld_pkg.sv -----
// Package for the S-record line decoder: payload structs, per-line state,
// status codes and the address length table. Depends on nothing.
package srld_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LENGTH    = 3'd1;
    localparam logic [2:0] ST_NO_S      = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_NON_HEX   = 3'd4;
    localparam logic [2:0] ST_SIZE      = 3'd5;
    localparam logic [2:0] ST_CHECKSUM  = 3'd6;

    localparam int FLAG_NO_S     = 0;
    localparam int FLAG_BAD_TYPE = 1;
    localparam int FLAG_NON_HEX  = 2;

    localparam logic [9:0] POS_MAX      = 10'd1023;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_F       = 8'h46;
    localparam logic [7:0] SUM_GOOD     = 8'hFF;
    localparam logic [3:0] TYPE_HEADER  = 4'd0;
    localparam logic [3:0] TYPE_DATA16  = 4'd1;
    localparam logic [3:0] TYPE_DATA32  = 4'd3;
    localparam logic [3:0] TYPE_RESVD   = 4'd4;
    localparam logic [3:0] TYPE_COUNT16 = 4'd5;
    localparam logic [3:0] TYPE_COUNT24 = 4'd6;
    localparam logic [3:0] TYPE_START32 = 4'd7;

    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        line_done;
        logic [2:0]  status;
        logic [3:0]  record_type;
        logic [31:0] start_address;
        logic [23:0] record_count;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  pos;
        logic [3:0]  type_digit;
        logic [7:0]  byte_count;
        logic [3:0]  high_nibble;
        logic [31:0] addr_acc;
        logic [7:0]  run_sum;
        logic [2:0]  flags;
    } t_line_state;

    function automatic logic [2:0] addr_bytes(input logic [3:0] type_digit);
        logic [2:0] len;
        unique case (type_digit)
            4'd0:    len = 3'd2;
            4'd1:    len = 3'd2;
            4'd2:    len = 3'd3;
            4'd3:    len = 3'd4;
            4'd4:    len = 3'd0;
            4'd5:    len = 3'd2;
            4'd6:    len = 3'd3;
            4'd7:    len = 3'd4;
            4'd8:    len = 3'd3;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/srld_step.sv -----
// Combinational decode of one character: next line state, kept values and
// the result item. Depends on srld_pkg.
module srld_step (
    input  srld_pkg::t_line_state i_state,
    input  logic [31:0]           i_kept_start,
    input  logic [23:0]           i_kept_count,
    input  srld_pkg::t_in_item    i_item,
    output srld_pkg::t_line_state o_next_state,
    output logic [31:0]           o_next_kept_start,
    output logic [23:0]           o_next_kept_count,
    output logic                  o_result_valid,
    output srld_pkg::t_out_item   o_result
);

    srld_pkg::t_line_state upd;
    logic [7:0]  c;
    logic        is_digit;
    logic        hex_ok;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [8:0]  k;
    logic [2:0]  alen_old;
    logic [2:0]  alen_new;
    logic        type_ok;
    logic        type_data;
    logic        wvalid;
    logic [31:0] waddr;
    logic [7:0]  wdata;
    logic [2:0]  status;
    logic [10:0] len;
    logic [10:0] exp_len;
    logic [31:0] kept_start;
    logic [23:0] kept_count;

    always_comb begin
        c         = i_item.character;
        is_digit  = (c >= srld_pkg::CHAR_ZERO) && (c <= srld_pkg::CHAR_NINE);
        hex_ok    = is_digit || ((c >= srld_pkg::CHAR_A) && (c <= srld_pkg::CHAR_F));
        nib       = is_digit ? c[3:0] : (hex_ok ? c[3:0] + 4'd9 : 4'd0);
        byte_val  = {i_state.high_nibble, nib};
        k         = i_state.pos[9:1] - 9'd1;
        alen_old  = srld_pkg::addr_bytes(i_state.type_digit);
        type_ok   = !i_state.flags[srld_pkg::FLAG_BAD_TYPE];
        type_data = (i_state.type_digit >= srld_pkg::TYPE_DATA16)
                    && (i_state.type_digit <= srld_pkg::TYPE_DATA32);

        upd        = i_state;
        kept_start = i_kept_start;
        kept_count = i_kept_count;
        wvalid     = 1'b0;
        waddr      = 32'd0;
        wdata      = 8'd0;
        status     = srld_pkg::ST_OK;

        if (i_state.pos == 10'd0) begin
            if (c != srld_pkg::CHAR_S) begin
                upd.flags[srld_pkg::FLAG_NO_S] = 1'b1;
            end
        end else if (i_state.pos == 10'd1) begin
            if (is_digit) begin
                upd.type_digit = c[3:0];
                if (c[3:0] == srld_pkg::TYPE_RESVD) begin
                    upd.flags[srld_pkg::FLAG_BAD_TYPE] = 1'b1;
                end
            end else begin
                upd.type_digit = srld_pkg::TYPE_HEADER;
                upd.flags[srld_pkg::FLAG_BAD_TYPE] = 1'b1;
            end
        end else begin
            if (!hex_ok) begin
                upd.flags[srld_pkg::FLAG_NON_HEX] = 1'b1;
            end
            if (!i_state.pos[0]) begin
                upd.high_nibble = nib;
            end else begin
                upd.run_sum = i_state.run_sum + byte_val;
                if (k == 9'd0) begin
                    upd.byte_count = byte_val;
                end else if (type_ok) begin
                    if (k <= {6'd0, alen_old}) begin
                        upd.addr_acc = {i_state.addr_acc[23:0], byte_val};
                    end else if ((k < {1'b0, i_state.byte_count}) && type_data) begin
                        wvalid = 1'b1;
                        wdata  = byte_val;
                        waddr  = i_state.addr_acc + 32'(k - {6'd0, alen_old} - 9'd1);
                    end
                end
            end
        end

        alen_new = srld_pkg::addr_bytes(upd.type_digit);
        len      = {1'b0, i_state.pos} + 11'd1;
        exp_len  = 11'd4 + {2'd0, upd.byte_count, 1'b0};

        if (i_item.line_end) begin
            if (!i_state.pos[0] || (i_state.pos < 10'd7)) begin
                status = srld_pkg::ST_LENGTH;
            end else if (upd.flags[srld_pkg::FLAG_NO_S]) begin
                status = srld_pkg::ST_NO_S;
            end else if (upd.flags[srld_pkg::FLAG_BAD_TYPE]) begin
                status = srld_pkg::ST_BAD_TYPE;
            end else if (upd.flags[srld_pkg::FLAG_NON_HEX]) begin
                status = srld_pkg::ST_NON_HEX;
            end else if (upd.type_digit == srld_pkg::TYPE_HEADER) begin
                status = srld_pkg::ST_OK;
            end else if ((len != exp_len) || (upd.byte_count <= {5'd0, alen_new})) begin
                status = srld_pkg::ST_SIZE;
            end else begin
                status = (upd.run_sum != srld_pkg::SUM_GOOD) ? srld_pkg::ST_CHECKSUM
                                                              : srld_pkg::ST_OK;
                if ((upd.type_digit == srld_pkg::TYPE_COUNT16)
                        || (upd.type_digit == srld_pkg::TYPE_COUNT24)) begin
                    kept_count = upd.addr_acc[23:0];
                end else if (upd.type_digit >= srld_pkg::TYPE_START32) begin
                    kept_start = upd.addr_acc;
                end
            end
        end

        o_result_valid              = wvalid || i_item.line_end;
        o_result.write_valid        = wvalid;
        o_result.write_address      = waddr;
        o_result.write_data         = wdata;
        o_result.line_done          = i_item.line_end;
        o_result.status             = status;
        o_result.record_type        = upd.type_digit;
        o_result.start_address      = kept_start;
        o_result.record_count       = kept_count;
        o_next_kept_start           = kept_start;
        o_next_kept_count           = kept_count;

        if (i_item.line_end) begin
            o_next_state = '0;
        end else begin
            o_next_state     = upd;
            o_next_state.pos = (i_state.pos < srld_pkg::POS_MAX) ? i_state.pos + 10'd1
                                                                  : srld_pkg::POS_MAX;
        end
    end

endmodule

// ----- hw/rtl/srld_core_regs.sv -----
// Input register, line state registers and result register around the
// character decode. Depends on srld_pkg and srld_step.
module srld_core_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srld_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srld_pkg::t_out_item o_out
);

    logic                  r_in_valid;
    srld_pkg::t_in_item    r_in;
    srld_pkg::t_line_state r_state;
    srld_pkg::t_line_state n_state;
    logic [31:0]           r_kept_start;
    logic [31:0]           n_kept_start;
    logic [23:0]           r_kept_count;
    logic [23:0]           n_kept_count;
    logic                  r_out_valid;
    srld_pkg::t_out_item   r_out;
    srld_pkg::t_out_item   result;
    logic                  result_valid;
    logic                  fire;

    srld_step u_step (
        .i_state          (r_state),
        .i_kept_start     (r_kept_start),
        .i_kept_count     (r_kept_count),
        .i_item           (r_in),
        .o_next_state     (n_state),
        .o_next_kept_start(n_kept_start),
        .o_next_kept_count(n_kept_count),
        .o_result_valid   (result_valid),
        .o_result         (result)
    );

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_kept_start <= 32'd0;
            r_kept_count <= 24'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_state      <= n_state;
                r_kept_start <= n_kept_start;
                r_kept_count <= n_kept_count;
                r_out_valid  <= result_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (fire && result_valid) begin
            r_out <= result;
        end
    end

endmodule

// ----- hw/rtl/srecord_line_decoder_core.sv -----
// Top level of the S-record line decoder: one ASCII character per transfer
// in, memory writes and line status out. Depends on srld_pkg, srld_core_regs.
// Each character is registered at the input and decoded; any result is registered at the output.
// Throughput: one character per cycle, set by the input and result registers, unless a held result stalls the input.
// Reset (synchronous, active low) clears the line state and kept values.
module srecord_line_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srld_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srld_pkg::t_out_item o_out
);

    srld_core_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule
